// ===== rtl/char_class_bitmap_builder_macros.svh =====
// assertion macros used by char_class_bitmap_builder.sv
`ifndef CHAR_CLASS_BITMAP_BUILDER_MACROS_SVH
`define CHAR_CLASS_BITMAP_BUILDER_MACROS_SVH

// same-cycle implication, disabled during reset
`define CCBB_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define CCBB_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/ccbb_pkg.sv =====
// ----------------------------------------------------------------------------
// ccbb_pkg
// Types, character codes and mask helpers for the character class builder.
// ----------------------------------------------------------------------------
package ccbb_pkg;

   localparam int BYTE_BITS     = 8;
   localparam int SET_BITS      = 256;
   localparam int WORD_BITS     = 64;
   localparam int WORD_COUNT    = SET_BITS / WORD_BITS;
   localparam int INDEX_BITS    = $clog2(WORD_COUNT);
   localparam int ALPHABET_SIZE = 256;

   typedef logic [BYTE_BITS-1:0]  byte_type;
   typedef logic [SET_BITS-1:0]   set_type;
   typedef logic [INDEX_BITS-1:0] index_type;
   typedef logic [WORD_COUNT-1:0][WORD_BITS-1:0] word_array_type;

   localparam byte_type  CH_CARET  = 8'h5E;
   localparam byte_type  CH_DASH   = 8'h2D;
   localparam byte_type  CH_CLOSE  = 8'h5D;
   localparam byte_type  CH_OPEN   = 8'h5B;
   localparam byte_type  BYTE_MAX  = 8'hFF;
   localparam byte_type  BYTE_ZERO = 8'h00;
   localparam index_type LAST_WORD_INDEX = index_type'(WORD_COUNT - 1);

   typedef enum logic [1:0] {
      PH_FIRST,
      PH_BODY_START,
      PH_AFTER_CARET,
      PH_BODY
   } phase_type;

   // inclusive range lo..hi, bytes outside the alphabet never set
   function automatic set_type range_mask(input byte_type lo, input byte_type hi,
                                          input int alpha);
      set_type m;
      m = '0;
      for (int i = 0; i < SET_BITS; i++) begin
         m[i] = (byte_type'(i) >= lo) && (byte_type'(i) <= hi) && (i < alpha);
      end
      return m;
   endfunction

   function automatic set_type apply_mask(input set_type s, input set_type m,
                                          input logic neg);
      return neg ? (s & ~m) : (s | m);
   endfunction

endpackage

// ===== rtl/char_class_bitmap_builder.sv =====
// ----------------------------------------------------------------------------
// char_class_bitmap_builder
// Builds a 256-bit membership set from the bytes of a regex character class.
// ----------------------------------------------------------------------------
// the first result word is offered in the cycle after the final byte is taken
// throughput: one class byte per cycle; a final byte gives four words (error: one)
// a final byte waits while the words of the previous class drain, but is taken
// in the cycle the last of those words goes out; other bytes are never held
// reset: synchronous, clears the parse phase and flags and the result valid; byte and set registers are not reset
`include "char_class_bitmap_builder_macros.svh"

module char_class_bitmap_builder
   import ccbb_pkg::*;
#(
   parameter int ALPHABET_SIZE = ccbb_pkg::ALPHABET_SIZE
)
(
   input  logic        clock,
   input  logic        reset,

   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] class_byte
   input  logic        req_tlast,   // final_byte

   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // [63:0] class_word
   output logic [2:0]  rsp_tuser,   // [1:0] word_index, [2] status
   output logic        rsp_tlast    // last_word
);

   // parse state
   phase_type phase_ff, phase_in;
   logic      bracketed_ff, bracketed_in;
   logic      negated_ff, negated_in;
   logic      ldash_ff, ldash_in;
   logic      held_valid_ff, held_valid_in;
   logic      after_valid_ff, after_valid_in;
   byte_type  prev_ff, prev_in;
   byte_type  held_ff, held_in;
   byte_type  after_ff, after_in;
   set_type   set_ff, set_in;

   // result buffer
   logic           out_busy_ff, out_busy_in;
   logic           out_err_ff, out_err_in;
   index_type      out_idx_ff, out_idx_in;
   word_array_type out_set_ff, out_set_in;

   logic     req_accept;
   logic     rsp_accept;
   logic     push;
   logic     finish;
   logic     err;
   logic     take;
   logic     strip;
   byte_type c;
   byte_type lo_a, hi_a, lo_b, hi_b;

   assign c          = req_tdata;
   assign req_tready = !out_busy_ff || !req_tlast || (rsp_tready && rsp_tlast);
   assign req_accept = req_tvalid && req_tready;
   assign rsp_accept = rsp_tvalid && rsp_tready;

   always_comb begin
      phase_in       = phase_ff;
      bracketed_in   = bracketed_ff;
      negated_in     = negated_ff;
      ldash_in       = ldash_ff;
      held_valid_in  = held_valid_ff;
      after_valid_in = after_valid_ff;
      prev_in        = prev_ff;
      held_in        = held_ff;
      after_in       = after_ff;
      set_in         = set_ff;
      push           = 1'b0;
      finish         = 1'b0;
      err            = 1'b0;
      take           = 1'b0;
      strip          = 1'b0;
      lo_a           = BYTE_ZERO;
      hi_a           = BYTE_ZERO;
      lo_b           = BYTE_ZERO;
      hi_b           = BYTE_ZERO;

      if (req_accept) begin
         if (phase_ff == PH_FIRST) begin
            bracketed_in   = 1'b0;
            negated_in     = 1'b0;
            ldash_in       = 1'b0;
            held_valid_in  = 1'b0;
            after_valid_in = 1'b0;
            prev_in        = BYTE_ZERO;
            held_in        = BYTE_ZERO;
            after_in       = BYTE_ZERO;
            set_in         = '0;
            phase_in       = PH_BODY_START;
            if (c == CH_OPEN) begin
               bracketed_in = 1'b1;
               prev_in      = c;
               err          = req_tlast;
            end else begin
               push   = 1'b1;
               finish = req_tlast;
            end
         end else if (req_tlast && bracketed_ff) begin
            // closing bracket is dropped
            if (c != CH_CLOSE) begin
               err = 1'b1;
            end else begin
               finish = 1'b1;
            end
         end else begin
            push   = 1'b1;
            finish = req_tlast;
         end

         if (push) begin
            if (phase_in == PH_BODY_START && c == CH_CARET) begin
               negated_in = 1'b1;
               set_in     = range_mask(BYTE_ZERO, BYTE_MAX, ALPHABET_SIZE);
               prev_in    = c;
               phase_in   = PH_AFTER_CARET;
            end else begin
               take = 1'b1;
               if (phase_in == PH_BODY_START || phase_in == PH_AFTER_CARET) begin
                  phase_in = PH_BODY;
                  if (c == CH_DASH) begin
                     // leading dash is a literal
                     ldash_in = 1'b1;
                     set_in   = apply_mask(set_in,
                                           range_mask(CH_DASH, CH_DASH, ALPHABET_SIZE),
                                           negated_in);
                     prev_in  = c;
                     take     = 1'b0;
                  end
               end
               if (take) begin
                  if (after_valid_in) begin
                     // held byte now has a real right neighbor
                     lo_a     = (held_in == CH_DASH) ? prev_in : held_in;
                     hi_a     = (held_in == CH_DASH) ? after_in : held_in;
                     set_in   = apply_mask(set_in, range_mask(lo_a, hi_a, ALPHABET_SIZE),
                                           negated_in);
                     prev_in  = held_in;
                     held_in  = after_in;
                     after_in = c;
                  end else if (held_valid_in) begin
                     after_in       = c;
                     after_valid_in = 1'b1;
                  end else begin
                     held_in       = c;
                     held_valid_in = 1'b1;
                  end
               end
            end
         end

         if (finish) begin
            if (after_valid_in) begin
               // trailing dash stays literal unless a leading one was taken
               strip  = (after_in == CH_DASH) && !ldash_in;
               lo_a   = (held_in == CH_DASH) ? prev_in : held_in;
               hi_a   = (held_in == CH_DASH) ? (strip ? BYTE_ZERO : after_in) : held_in;
               set_in = apply_mask(set_in, range_mask(lo_a, hi_a, ALPHABET_SIZE), negated_in);
               lo_b   = strip ? CH_DASH : ((after_in == CH_DASH) ? held_in : after_in);
               hi_b   = strip ? CH_DASH : ((after_in == CH_DASH) ? BYTE_ZERO : after_in);
               set_in = apply_mask(set_in, range_mask(lo_b, hi_b, ALPHABET_SIZE), negated_in);
            end else if (held_valid_in) begin
               lo_b   = (held_in == CH_DASH) ? (ldash_in ? prev_in : CH_DASH) : held_in;
               hi_b   = (held_in == CH_DASH) ? (ldash_in ? BYTE_ZERO : CH_DASH) : held_in;
               set_in = apply_mask(set_in, range_mask(lo_b, hi_b, ALPHABET_SIZE), negated_in);
            end
         end

         if (req_tlast) begin
            phase_in       = PH_FIRST;
            bracketed_in   = 1'b0;
            negated_in     = 1'b0;
            ldash_in       = 1'b0;
            held_valid_in  = 1'b0;
            after_valid_in = 1'b0;
            prev_in        = BYTE_ZERO;
            held_in        = BYTE_ZERO;
            after_in       = BYTE_ZERO;
         end
      end
   end

   always_comb begin
      out_busy_in = out_busy_ff;
      out_idx_in  = out_idx_ff;
      out_err_in  = out_err_ff;
      out_set_in  = out_set_ff;
      if (rsp_accept) begin
         if (rsp_tlast) begin
            out_busy_in = 1'b0;
         end else begin
            out_idx_in = out_idx_ff + index_type'(1);
         end
      end
      if (req_accept && req_tlast) begin
         out_busy_in = 1'b1;
         out_idx_in  = '0;
         out_err_in  = err;
         out_set_in  = set_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_FIRST;
         bracketed_ff   <= 1'b0;
         negated_ff     <= 1'b0;
         ldash_ff       <= 1'b0;
         held_valid_ff  <= 1'b0;
         after_valid_ff <= 1'b0;
         out_busy_ff    <= 1'b0;
         out_idx_ff     <= '0;
         out_err_ff     <= 1'b0;
      end else begin
         phase_ff       <= phase_in;
         bracketed_ff   <= bracketed_in;
         negated_ff     <= negated_in;
         ldash_ff       <= ldash_in;
         held_valid_ff  <= held_valid_in;
         after_valid_ff <= after_valid_in;
         out_busy_ff    <= out_busy_in;
         out_idx_ff     <= out_idx_in;
         out_err_ff     <= out_err_in;
      end
   end

   always_ff @(posedge clock) begin
      prev_ff    <= prev_in;
      held_ff    <= held_in;
      after_ff   <= after_in;
      set_ff     <= set_in;
      out_set_ff <= out_set_in;
   end

   assign rsp_tvalid = out_busy_ff;
   assign rsp_tdata  = out_err_ff ? '0 : out_set_ff[out_idx_ff];
   assign rsp_tuser  = {out_err_ff, out_idx_ff};
   assign rsp_tlast  = out_err_ff || (out_idx_ff == LAST_WORD_INDEX);

   `CCBB_ASSERT_NEXT(a_final_loads, clock, reset, req_accept && req_tlast, phase_ff == PH_FIRST && out_busy_ff && out_idx_ff == '0, "final byte did not load a result")
   `CCBB_ASSERT_NEXT(a_word_advance, clock, reset, rsp_accept && !rsp_tlast, rsp_tvalid && out_idx_ff == index_type'($past(out_idx_ff) + index_type'(1)), "word index did not advance")
   `CCBB_ASSERT_NOW(a_err_single, clock, reset, out_busy_ff && out_err_ff, out_idx_ff == '0 && rsp_tlast, "error result is not a single word")
   `CCBB_ASSERT_NOW(a_lookahead_order, clock, reset, !held_valid_ff, !after_valid_ff, "lookahead byte without held byte")

endmodule

// ===== verif/char_class_bitmap_builder_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// char_class_bitmap_builder_tb
// Sends character class texts byte by byte and checks every result word
// against a set built in parallel by the bench, with random gaps on both sides outside the back-to-back test.
// ----------------------------------------------------------------------------
module char_class_bitmap_builder_tb
   import ccbb_pkg::*;
();

   localparam int  CYCLE_LIMIT   = 200000;
   localparam int  DRAIN_CYCLES  = 12;
   localparam int  IDLE_PERCENT  = 38;
   localparam int  RANDOM_TARGET = 180;
   localparam int  PRINT_CAP     = 50;
   localparam logic STATUS_OK            = 1'b0;
   localparam logic STATUS_MISSING_CLOSE = 1'b1;

   typedef struct packed {
      index_type             quarter;
      logic [WORD_BITS-1:0]  bits;
      logic                  status;
      logic                  is_last;
   } class_word_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;   // [7:0] class_byte
   logic        req_tlast;   // final_byte
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [63:0] rsp_tdata;   // [63:0] class_word
   logic [2:0]  rsp_tuser;   // [1:0] word_index, [2] status
   logic        rsp_tlast;   // last_word

   class_word_type pending_words[$];
   int             mismatch_count;
   int             bytes_sent;
   int             cycle_count;
   bit             steady;

   // set under construction, mirrored from the text seen so far
   set_type   class_set;
   phase_type phase;
   logic      in_brackets, negate, dash_lead, held_v, next_v;
   byte_type  prev_b, held_b, next_b;

   char_class_bitmap_builder uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ---------------- set prediction ----------------

   function automatic void clear_parse();
      phase       = PH_FIRST;
      in_brackets = 1'b0;
      negate      = 1'b0;
      dash_lead   = 1'b0;
      prev_b      = BYTE_ZERO;
      held_b      = BYTE_ZERO;
      held_v      = 1'b0;
      next_b      = BYTE_ZERO;
      next_v      = 1'b0;
   endfunction

   function automatic void mark_byte(input byte_type b);
      if (int'(b) < ALPHABET_SIZE) class_set[b] = ~negate;
   endfunction

   function automatic void mark_span(input byte_type lo, input byte_type hi);
      for (int i = int'(lo); i <= int'(hi); i++) mark_byte(byte_type'(i));
   endfunction

   // a held dash becomes a range once its right end is known
   function automatic void settle_held(input byte_type right_end);
      if (held_b == CH_DASH) mark_span(prev_b, right_end);
      else mark_byte(held_b);
   endfunction

   function automatic void push_body(input byte_type c);
      if (phase == PH_BODY_START && c == CH_CARET) begin
         negate    = 1'b1;
         class_set = '0;
         for (int i = 0; i < ALPHABET_SIZE; i++) class_set[i] = 1'b1;
         prev_b = c;
         phase  = PH_AFTER_CARET;
         return;
      end
      if (phase == PH_BODY_START || phase == PH_AFTER_CARET) begin
         phase = PH_BODY;
         if (c == CH_DASH) begin
            dash_lead = 1'b1;
            mark_byte(CH_DASH);
            prev_b = c;
            return;
         end
      end
      if (next_v) begin
         settle_held(next_b);
         prev_b = held_b;
         held_b = next_b;
         next_b = c;
      end else if (held_v) begin
         next_b = c;
         next_v = 1'b1;
      end else begin
         held_b = c;
         held_v = 1'b1;
      end
   endfunction

   function automatic void finish_body();
      logic strip;
      if (next_v) begin
         // trailing dash is literal only without a leading one
         strip = (next_b == CH_DASH) && !dash_lead;
         settle_held(strip ? BYTE_ZERO : next_b);
         if (strip) mark_byte(CH_DASH);
         else if (next_b == CH_DASH) mark_span(held_b, BYTE_ZERO);
         else mark_byte(next_b);
      end else if (held_v) begin
         if (held_b == CH_DASH) begin
            if (!dash_lead) mark_byte(CH_DASH);
            else mark_span(prev_b, BYTE_ZERO);
         end else begin
            mark_byte(held_b);
         end
      end
   endfunction

   function automatic void emit_set();
      class_word_type w;
      for (int k = 0; k < WORD_COUNT; k++) begin
         w.quarter = index_type'(k);
         w.bits    = class_set[k*WORD_BITS +: WORD_BITS];
         w.status  = STATUS_OK;
         w.is_last = (index_type'(k) == LAST_WORD_INDEX);
         pending_words.push_back(w);
      end
      clear_parse();
   endfunction

   function automatic void emit_missing_close();
      class_word_type w;
      w.quarter = '0;
      w.bits    = '0;
      w.status  = STATUS_MISSING_CLOSE;
      w.is_last = 1'b1;
      pending_words.push_back(w);
      clear_parse();
   endfunction

   function automatic void predict_byte(input byte_type c, input logic fin);
      if (phase == PH_FIRST) begin
         clear_parse();
         class_set = '0;
         phase     = PH_BODY_START;
         if (c == CH_OPEN) begin
            in_brackets = 1'b1;
            prev_b      = c;
            if (fin) emit_missing_close();
            return;
         end
      end else if (fin && in_brackets) begin
         if (c != CH_CLOSE) begin
            emit_missing_close();
         end else begin
            finish_body();
            emit_set();
         end
         return;
      end
      push_body(c);
      if (fin) begin
         finish_body();
         emit_set();
      end
   endfunction

   // ---------------- driving ----------------

   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_tready <= steady ? 1'b1 : ($urandom_range(0, 99) >= IDLE_PERCENT);
      end
   end

   // called and returns at a falling edge
   task automatic send_class_byte(input byte_type c, input logic fin);
      if (!steady) begin
         while ($urandom_range(0, 99) < IDLE_PERCENT) begin
            req_tvalid <= 1'b0;
            @(negedge clock);
         end
      end
      req_tvalid <= 1'b1;
      req_tdata  <= c;
      req_tlast  <= fin;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_byte(c, fin);
      bytes_sent++;
      @(negedge clock);
   endtask

   task automatic send_bytes(input byte_type text[$]);
      foreach (text[i]) send_class_byte(text[i], i == text.size() - 1);
   endtask

   task automatic send_text(input string s);
      byte_type text[$];
      for (int i = 0; i < s.len(); i++) text.push_back(byte_type'(s[i]));
      send_bytes(text);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (pending_words.size() != 0) @(negedge clock);
   endtask

   function automatic byte_type pick_byte();
      case ($urandom_range(0, 15))
         0, 1, 2, 3: return CH_DASH;
         4:          return CH_CARET;
         5:          return CH_CLOSE;
         6:          return CH_OPEN;
         7:          return BYTE_ZERO;
         8:          return BYTE_MAX;
         default:    return byte_type'($urandom_range(0, 255));
      endcase
   endfunction

   task automatic send_random_class();
      byte_type text[$];
      byte_type tail;
      int       kind;
      kind = $urandom_range(0, 9);
      if (kind <= 7) begin
         // well formed, bracketed most of the time
         if (kind != 7) text.push_back(CH_OPEN);
         if ($urandom_range(0, 99) < 30) text.push_back(CH_CARET);
         if ($urandom_range(0, 99) < 30) text.push_back(CH_DASH);
         repeat ($urandom_range(0, 6)) text.push_back(pick_byte());
         if ($urandom_range(0, 99) < 25) text.push_back(CH_DASH);
         if (kind != 7) text.push_back(CH_CLOSE);
         if (text.size() == 0) text.push_back(pick_byte());
      end else if (kind == 8) begin
         // opening bracket and random bytes, most often ending in a byte that is not a closing one
         text.push_back(CH_OPEN);
         repeat ($urandom_range(0, 5)) text.push_back(pick_byte());
         if ($urandom_range(0, 3) != 0) begin
            do tail = pick_byte(); while (tail == CH_CLOSE);
            text.push_back(tail);
         end
      end else begin
         repeat ($urandom_range(1, 6)) text.push_back(byte_type'($urandom_range(0, 255)));
      end
      send_bytes(text);
   endtask

   // ---------------- checking ----------------

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      mismatch_count++;
      if (mismatch_count <= PRINT_CAP)
         $display("%0t: %s got %h want %h", $time, what, got, want);
   endtask

   always @(posedge clock) begin : check_words
      class_word_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_words.size() == 0) begin
            report_mismatch("word with none expected", rsp_tdata, '0);
         end else begin
            want = pending_words.pop_front();
            if (rsp_tuser[1:0] !== want.quarter)
               report_mismatch("word_index", 64'(rsp_tuser[1:0]), 64'(want.quarter));
            if (rsp_tdata !== want.bits)
               report_mismatch("class_word", rsp_tdata, want.bits);
            if (rsp_tuser[2] !== want.status)
               report_mismatch("status", 64'(rsp_tuser[2]), 64'(want.status));
            if (rsp_tlast !== want.is_last)
               report_mismatch("last_word", 64'(rsp_tlast), 64'(want.is_last));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // ---------------- tests ----------------

   task automatic test_directed();
      byte_type text[$];
      send_text("[");        // lone opening bracket
      send_text("[]");       // empty body
      send_text("[^]");      // empty negated body
      text = {CH_OPEN, BYTE_ZERO, CH_DASH, BYTE_MAX, CH_CLOSE};
      send_bytes(text);      // full range, byte zero included
      send_text("[z-a]");    // reversed range
      send_text("[-a-]");    // leading dash, dash before the end
      send_text("[ab");      // missing closing bracket
      send_text("^");
      send_text("a-");       // trailing dash kept literal
   endtask

   task automatic test_random_classes();
      while (bytes_sent < RANDOM_TARGET) send_random_class();
   endtask

   // no gaps on either side; single byte classes queue finals behind draining words
   task automatic test_back_to_back();
      steady = 1'b1;
      repeat (12) send_class_byte(byte_type'($urandom_range(0, 255)), 1'b1);
      repeat (4) send_random_class();
      steady = 1'b0;
   endtask

   task automatic test_pause_until_drained();
      repeat (4) begin
         send_random_class();
         wait_drained();
      end
   endtask

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tlast  = 1'b0;
      steady     = 1'b0;
      mismatch_count = 0;
      bytes_sent     = 0;
      cycle_count    = 0;
      class_set      = '0;
      clear_parse();
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed();
      test_pause_until_drained();
      test_back_to_back();
      test_random_classes();

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

// ===== char_class_bitmap_builder.f =====
+incdir+rtl
rtl/ccbb_pkg.sv
rtl/char_class_bitmap_builder.sv
verif/char_class_bitmap_builder_tb.sv
